// ===== hdl/rad_pkg.sv =====
`default_nettype none
package rad_pkg;
    localparam int NUM_RESOURCES = 4;
    localparam int NUM_PROCESSES = 8;
    localparam int NUM_AMOUNT_FIELDS = 4;
    localparam int NUM_OUTPUTS = 8;
    localparam int CNT_W = 8;

    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_ABORT   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_WAITING  = 3'd1,
        ST_REFUSED  = 3'd2,
        ST_RELEASED = 3'd3,
        ST_ABORTED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP,
        S_FIT,
        S_DET_INIT,
        S_DET_SCAN,
        S_WAKE,
        S_OUT
    } t_state;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== hdl/rad_if.sv =====
`default_nettype none
interface rad_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] process;
    logic [7:0] amount_0;
    logic [7:0] amount_1;
    logic [7:0] amount_2;
    logic [7:0] amount_3;
    modport source(output valid, action, process, amount_0, amount_1, amount_2, amount_3,
                   input ready);
    modport sink(input valid, action, process, amount_0, amount_1, amount_2, amount_3,
                 output ready);
endinterface

interface rad_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] deadlock_mask;
    logic [7:0] woken_mask;
    logic [7:0] waiting_mask;
    logic [7:0] free_0;
    logic [7:0] free_1;
    logic [7:0] free_2;
    logic [7:0] free_3;
    modport source(output valid, status, deadlock_mask, woken_mask, waiting_mask,
                   free_0, free_1, free_2, free_3, input ready);
    modport sink(input valid, status, deadlock_mask, woken_mask, waiting_mask,
                 free_0, free_1, free_2, free_3, output ready);
endinterface
`default_nettype wire

// ===== hdl/rad_ctrl.sv =====
`default_nettype none
module rad_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  wire               i_is_request,
    input  wire               i_is_wake_op,
    input  wire               i_fits,
    input  wire               i_last,
    input  wire               i_progress,
    output rad_pkg::t_state   o_state
);
    rad_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rad_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            rad_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = rad_pkg::S_OP;
            end
            rad_pkg::S_OP: begin
                if (i_is_request) n_state = rad_pkg::S_FIT;
                else if (i_is_wake_op) n_state = rad_pkg::S_WAKE;
                else n_state = rad_pkg::S_OUT;
            end
            rad_pkg::S_FIT: n_state = i_fits ? rad_pkg::S_OUT : rad_pkg::S_DET_INIT;
            rad_pkg::S_DET_INIT: n_state = rad_pkg::S_DET_SCAN;
            rad_pkg::S_DET_SCAN: begin
                if (i_last && !i_progress) n_state = rad_pkg::S_OUT;
            end
            rad_pkg::S_WAKE: begin
                if (i_last) n_state = rad_pkg::S_OUT;
            end
            rad_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = rad_pkg::S_IDLE;
            end
            default: n_state = rad_pkg::S_IDLE;
        endcase
    end
    assign o_state = r_state;
endmodule
`default_nettype wire

// ===== hdl/rad_dp.sv =====
`default_nettype none
module rad_dp #(
    parameter int NR = rad_pkg::NUM_RESOURCES,
    parameter int NP = rad_pkg::NUM_PROCESSES
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  rad_pkg::t_state                     i_state,
    input  wire                                 i_load,
    input  wire  [1:0]                          i_action,
    input  wire  [2:0]                          i_process,
    input  wire  [rad_pkg::NUM_AMOUNT_FIELDS-1:0][7:0] i_amount,
    input  wire                                 i_cfg_we,
    input  wire  [1:0]                          i_cfg_idx,
    input  wire  [7:0]                          i_cfg_data,
    output logic                                o_is_request,
    output logic                                o_is_wake_op,
    output logic                                o_fits,
    output logic                                o_last,
    output logic                                o_progress,
    output logic [2:0]                          o_status,
    output logic [7:0]                          o_dead,
    output logic [7:0]                          o_woken,
    output logic [7:0]                          o_waiting,
    output logic [rad_pkg::NUM_AMOUNT_FIELDS-1:0][7:0] o_free
);
    localparam int PW = $clog2(NP);
    localparam int W = rad_pkg::CNT_W;

    logic [NR-1:0][W-1:0]         r_free;
    logic [NP-1:0][NR-1:0][W-1:0] r_held, r_pend;
    logic [NP-1:0]                r_wait, r_done, r_dead, r_woken;
    logic [NR-1:0][W+4:0]         r_work;
    logic [1:0]                   r_act;
    logic [NR-1:0][W-1:0]         r_amt;
    logic [PW-1:0]                r_p, r_scan;
    logic                         r_valid_p, r_prog;
    logic [2:0]                   r_status;

    logic fit_scan, ok_det, fit_req;
    always_comb begin
        fit_scan = 1'b1;
        ok_det = 1'b1;
        fit_req = 1'b1;
        for (int r = 0; r < NR; r++) begin
            if (r_pend[r_scan][r] > r_free[r]) fit_scan = 1'b0;
            if ({5'd0, r_pend[r_scan][r]} > r_work[r]) ok_det = 1'b0;
            if (r_pend[r_p][r] > r_free[r]) fit_req = 1'b0;
        end
    end

    assign o_is_request = r_valid_p && r_act == rad_pkg::ACT_REQUEST && !r_wait[r_p];
    assign o_is_wake_op = r_valid_p && ((r_act == rad_pkg::ACT_RELEASE && !r_wait[r_p])
                                        || r_act == rad_pkg::ACT_ABORT);
    assign o_fits = fit_req;
    assign o_last = r_scan == PW'(NP - 1);
    assign o_progress = r_prog || (!r_done[r_scan] && ok_det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '0;
            r_held <= '0;
            r_pend <= '0;
            r_wait <= '0;
        end else begin
            if (i_cfg_we && 32'(i_cfg_idx) < NR) r_free[i_cfg_idx] <= i_cfg_data;
            if (i_load) begin
                r_act <= i_action;
                r_valid_p <= 32'(i_process) < NP;
                r_p <= PW'(i_process);
                for (int r = 0; r < NR; r++)
                    r_amt[r] <= (r < rad_pkg::NUM_AMOUNT_FIELDS) ? i_amount[r] : '0;
                r_dead <= '0;
                r_woken <= '0;
                r_status <= rad_pkg::ST_REFUSED;
            end
            unique case (i_state)
                rad_pkg::S_OP: begin
                    r_scan <= '0;
                    if (o_is_request) begin
                        r_pend[r_p] <= r_amt;
                    end else if (o_is_wake_op) begin
                        for (int r = 0; r < NR; r++) begin
                            if (r_act == rad_pkg::ACT_ABORT) begin
                                r_free[r] <= rad_pkg::sat_add(r_free[r], r_held[r_p][r]);
                                r_held[r_p][r] <= '0;
                                r_pend[r_p][r] <= '0;
                            end else if (r_held[r_p][r] >= r_amt[r]) begin
                                r_held[r_p][r] <= r_held[r_p][r] - r_amt[r];
                                r_free[r] <= rad_pkg::sat_add(r_free[r], r_amt[r]);
                            end
                        end
                        if (r_act == rad_pkg::ACT_ABORT) begin
                            r_wait[r_p] <= 1'b0;
                            r_status <= rad_pkg::ST_ABORTED;
                        end else begin
                            r_status <= rad_pkg::ST_RELEASED;
                        end
                    end
                end
                rad_pkg::S_FIT: begin
                    if (fit_req) begin
                        for (int r = 0; r < NR; r++) begin
                            r_held[r_p][r] <= rad_pkg::sat_add(r_held[r_p][r], r_pend[r_p][r]);
                            r_free[r] <= r_free[r] - r_pend[r_p][r];
                            r_pend[r_p][r] <= '0;
                        end
                        r_status <= rad_pkg::ST_GRANTED;
                    end else begin
                        r_wait[r_p] <= 1'b1;
                        r_status <= rad_pkg::ST_WAITING;
                    end
                end
                rad_pkg::S_DET_INIT: begin
                    r_scan <= '0;
                    r_prog <= 1'b0;
                    for (int r = 0; r < NR; r++) r_work[r] <= {5'd0, r_free[r]};
                    for (int p = 0; p < NP; p++) r_done[p] <= r_held[p] == '0;
                end
                rad_pkg::S_DET_SCAN: begin
                    if (!r_done[r_scan] && ok_det) begin
                        r_done[r_scan] <= 1'b1;
                        for (int r = 0; r < NR; r++)
                            r_work[r] <= r_work[r] + {5'd0, r_held[r_scan][r]};
                    end
                    r_scan <= o_last ? '0 : r_scan + 1'b1;
                    r_prog <= o_last ? 1'b0 : o_progress;
                    if (o_last && !o_progress) begin
                        for (int p = 0; p < NP; p++)
                            r_dead[p] <= !(r_done[p] || (p == 32'(r_scan) && ok_det));
                    end
                end
                rad_pkg::S_WAKE: begin
                    if (r_wait[r_scan] && fit_scan) begin
                        for (int r = 0; r < NR; r++) begin
                            r_held[r_scan][r] <= rad_pkg::sat_add(r_held[r_scan][r],
                                                                  r_pend[r_scan][r]);
                            r_free[r] <= r_free[r] - r_pend[r_scan][r];
                            r_pend[r_scan][r] <= '0;
                        end
                        r_wait[r_scan] <= 1'b0;
                        r_woken[r_scan] <= 1'b1;
                    end
                    r_scan <= r_scan + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_status = r_status;
    always_comb begin
        o_dead = '0;
        o_woken = '0;
        o_waiting = '0;
        o_free = '0;
        for (int p = 0; p < NP && p < 8; p++) begin
            o_dead[p] = r_dead[p];
            o_woken[p] = r_woken[p];
            o_waiting[p] = r_wait[p];
        end
        for (int r = 0; r < NR && r < rad_pkg::NUM_AMOUNT_FIELDS; r++) o_free[r] = r_free[r];
    end
endmodule
`default_nettype wire

// ===== hdl/resource_allocator_deadlock_detect.sv =====
`default_nettype none
// One item at a time: an abort, or a release by a process that is not waiting, runs one
// wake check per process, and a blocked request runs the detector, one process per cycle,
// repeating full scans while any process finishes (at most NUM_PROCESSES plus one scans).
// The result is held until taken, then input is accepted.
module resource_allocator_deadlock_detect #(
    parameter int NUM_RESOURCES = rad_pkg::NUM_RESOURCES,
    parameter int NUM_PROCESSES = rad_pkg::NUM_PROCESSES
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rad_in_if.sink    in_ch,
    rad_out_if.source out_ch,
    input  wire       i_cfg_we,
    input  wire [1:0] i_cfg_idx,
    input  wire [7:0] i_cfg_data
);
    rad_pkg::t_state st;
    logic is_req, is_wake, fits, last, prog, in_ready, out_valid;
    logic [rad_pkg::NUM_AMOUNT_FIELDS-1:0][7:0] free;

    rad_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid), .o_in_ready(in_ready),
        .o_out_valid(out_valid), .i_out_ready(out_ch.ready), .i_is_request(is_req),
        .i_is_wake_op(is_wake), .i_fits(fits), .i_last(last), .i_progress(prog),
        .o_state(st));

    rad_dp #(.NR(NUM_RESOURCES), .NP(NUM_PROCESSES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_state(st), .i_load(in_ch.valid && in_ready),
        .i_action(in_ch.action), .i_process(in_ch.process),
        .i_amount({in_ch.amount_3, in_ch.amount_2, in_ch.amount_1, in_ch.amount_0}),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_is_request(is_req), .o_is_wake_op(is_wake), .o_fits(fits), .o_last(last),
        .o_progress(prog), .o_status(out_ch.status), .o_dead(out_ch.deadlock_mask),
        .o_woken(out_ch.woken_mask), .o_waiting(out_ch.waiting_mask), .o_free(free));

    assign in_ch.ready = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.free_0 = free[0];
    assign out_ch.free_1 = free[1];
    assign out_ch.free_2 = free[2];
    assign out_ch.free_3 = free[3];
endmodule
`default_nettype wire

// ===== hdl/rad_checker.sv =====
`default_nettype none
module rad_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [2:0] i_status,
    input wire [7:0] i_deadlock_mask,
    input wire [7:0] i_woken_mask
);
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("output changed under stall");
    a_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != rad_pkg::ST_WAITING |-> i_deadlock_mask == 8'd0)
        else $error("deadlock mask without wait");
    a_woken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != rad_pkg::ST_RELEASED && i_status != rad_pkg::ST_ABORTED
        |-> i_woken_mask == 8'd0)
        else $error("woken mask without release");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");
endmodule

bind resource_allocator_deadlock_detect rad_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_status(out_ch.status),
    .i_deadlock_mask(out_ch.deadlock_mask), .i_woken_mask(out_ch.woken_mask));
`default_nettype wire
